>>> design/lltd_pkg.sv
// ----------------------------------------------------------------------------
// lltd_pkg
// Shared types and constants of the least-loaded task dispatcher.
// ----------------------------------------------------------------------------
package lltd_pkg;

    localparam int unsigned NUM_QUEUES = 4;
    localparam int unsigned QID_W      = 2;
    localparam int unsigned DEPTH_BITS = 16;
    localparam int unsigned HW_W       = 16;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned REG_IDX_W  = 3;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam logic [HW_W-1:0]       HW_RESET  = HW_W'(1024);

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_HW_Q0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HW_Q1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HW_Q2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HW_Q3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SHARE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DRAIN = 3'd5;

    // Request modes
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TAKE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [NUM_QUEUES-1:0][HW_W-1:0] q_limit;
        logic [NUM_QUEUES-1:0]           share_mask;
        logic                            draining;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan_step;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } t_status;

    // Room for one more task: below the limit and below counter saturation
    function automatic logic has_room(input logic [DEPTH_BITS-1:0] depth,
                                      input logic [HW_W-1:0]       limit);
        has_room = (depth < DEPTH_BITS'(limit)) && (depth != DEPTH_MAX);
    endfunction

endpackage

>>> design/lltd_ctrl.sv
// ----------------------------------------------------------------------------
// lltd_ctrl
// Sequencer: accepts one request, steps the queue scan, loads the result.
// ----------------------------------------------------------------------------
module lltd_ctrl import lltd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    // Result slot can take a new result when empty or being emptied now
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.need_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // No request is taken while in reset or busy
    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;

    // An accepted request always leaves idle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted request did not leave idle");

    // A finished request waits while the previous result is still held
    a_finish_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_out_valid && i_out_stall)
            |=> (r_state == S_FINISH && r_out_valid))
        else $error("result slot overwritten while stalled");

endmodule

>>> design/lltd_dp.sv
// ----------------------------------------------------------------------------
// lltd_dp
// Datapath: queue depth counters, one-queue-per-cycle least-loaded scan,
// depth update and result register.
// ----------------------------------------------------------------------------
module lltd_dp import lltd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_in_mode,
    input  logic                  i_in_auto_pick,
    input  logic [QID_W-1:0]      i_in_queue_id,
    input  logic [DATA_W-1:0]     i_in_task_handle,
    input  logic [DATA_W-1:0]     i_in_task_argument,
    output logic                  o_out_accepted,
    output logic [QID_W-1:0]      o_out_chosen_queue,
    output logic [DATA_W-1:0]     o_out_routed_handle,
    output logic [DATA_W-1:0]     o_out_routed_argument,
    output logic [DEPTH_BITS-1:0] o_out_depth_after
);

    // Latched request
    logic                  r_mode;
    logic                  r_auto;
    logic [QID_W-1:0]      r_qid;
    logic [DATA_W-1:0]     r_handle;
    logic [DATA_W-1:0]     r_arg;

    // Scan state
    logic [QID_W-1:0]      r_idx;
    logic                  r_found;
    logic [DEPTH_BITS-1:0] r_best;
    logic [QID_W-1:0]      r_pick;

    // Queue depths
    logic [NUM_QUEUES-1:0][DEPTH_BITS-1:0] r_depth;

    // Result register
    logic                  r_acc;
    logic [QID_W-1:0]      r_chosen;
    logic [DATA_W-1:0]     r_rh;
    logic [DATA_W-1:0]     r_ra;
    logic [DEPTH_BITS-1:0] r_dafter;

    logic                  w_add_ok;
    logic                  w_scanned;
    logic                  w_cand;
    logic [QID_W-1:0]      w_sel;
    logic [DEPTH_BITS-1:0] w_cur;
    logic                  w_do_take;
    logic                  w_do_add;
    logic [DEPTH_BITS-1:0] w_new;

    // Scan is needed for a valid automatic add; decided on the incoming request
    assign o_status.need_scan = (i_in_mode == MODE_ADD) && i_in_auto_pick
                              && (i_in_task_handle != '0) && !i_cfg.draining;
    assign o_status.scan_last = (r_idx == QID_W'(NUM_QUEUES - 1));

    // Candidate test for the queue under scan
    assign w_cand = i_cfg.share_mask[r_idx]
                 && has_room(r_depth[r_idx], i_cfg.q_limit[r_idx])
                 && (!r_found || (r_depth[r_idx] < r_best));

    // Target queue and update decision
    assign w_add_ok  = (r_mode == MODE_ADD) && (r_handle != '0) && !i_cfg.draining;
    assign w_scanned = w_add_ok && r_auto;
    assign w_sel     = w_scanned ? (r_found ? r_pick : '0) : r_qid;
    assign w_cur     = r_depth[w_sel];
    assign w_do_take = (r_mode == MODE_TAKE) && (w_cur != '0);
    assign w_do_add  = w_add_ok && (w_scanned ? r_found
                                              : has_room(w_cur, i_cfg.q_limit[w_sel]));

    always_comb begin
        w_new = w_cur;
        if (w_do_take) begin
            w_new = w_cur - 1'b1;
        end else if (w_do_add) begin
            w_new = w_cur + 1'b1;
        end
    end

    // Request latch and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_in_mode;
            r_auto   <= i_in_auto_pick;
            r_qid    <= i_in_queue_id;
            r_handle <= i_in_task_handle;
            r_arg    <= i_in_task_argument;
        end
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            if (w_cand) begin
                r_found <= 1'b1;
            end
        end
        if (i_cmd.scan_step && w_cand) begin
            r_best <= r_depth[r_idx];
            r_pick <= r_idx;
        end
    end

    // Depth counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_cmd.finish) begin
            r_depth[w_sel] <= w_new;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_acc    <= w_do_take || w_do_add;
            r_chosen <= w_sel;
            r_rh     <= w_do_add ? r_handle : '0;
            r_ra     <= w_do_add ? r_arg : '0;
            r_dafter <= w_new;
        end
    end

    assign o_out_accepted        = r_acc;
    assign o_out_chosen_queue    = r_chosen;
    assign o_out_routed_handle   = r_rh;
    assign o_out_routed_argument = r_ra;
    assign o_out_depth_after     = r_dafter;

    // Depths change only when a request finishes
    a_depth_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.finish |=> $stable(r_depth))
        else $error("queue depth changed outside finish");

    // Scan index advances by one per step
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_step && !i_cmd.load) |=> (r_idx == $past(r_idx) + 1'b1))
        else $error("scan index did not advance");

    // A placed task never takes a queue beyond its limit
    a_add_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && w_do_add) |-> (w_new <= DEPTH_BITS'(i_cfg.q_limit[w_sel])))
        else $error("add placed beyond high-water limit");

endmodule

>>> design/least_loaded_task_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// least_loaded_task_dispatcher_unit
// Least-loaded queue dispatcher: depth counters for four work queues.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_stall): mode 0 adds a task, either to
//   queue_id or, with auto_pick, to the least loaded shared queue below its
//   high-water limit (lowest index on ties); mode 1 takes one from queue_id.
//   Result channel (o_out_valid / i_out_stall): exactly one result per
//   request, in order, with accepted flag, chosen queue, routed handle and
//   argument (zero unless placed) and the queue depth after the request.
//   Timing: one request is worked on at a time. A take, explicit add or
//   refused add goes through accept and finish; an automatic pick goes
//   through accept, a scan step per queue in index order, and finish.
//   The result appears the cycle after the finish cycle.
//   A finished result sits in an output register; the next request is taken
//   while it waits. If the receiver stalls, finishing the following request
//   holds until the register is freed.
//   Reset (synchronous, active low) clears all depths, the result slot, and
//   sets limits to 1024, share mask to all queues and draining off.
//   Configuration: APB-style, register i at byte address 4*i; write only
//   while the block is idle.
// ----------------------------------------------------------------------------
module least_loaded_task_dispatcher_unit import lltd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_in_mode,
    input  logic                  i_in_auto_pick,
    input  logic [QID_W-1:0]      i_in_queue_id,
    input  logic [DATA_W-1:0]     i_in_task_handle,
    input  logic [DATA_W-1:0]     i_in_task_argument,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_out_accepted,
    output logic [QID_W-1:0]      o_out_chosen_queue,
    output logic [DATA_W-1:0]     o_out_routed_handle,
    output logic [DATA_W-1:0]     o_out_routed_argument,
    output logic [DEPTH_BITS-1:0] o_out_depth_after
);

    t_cfg                 r_cfg;
    t_cmd                 w_cmd;
    t_status              w_status;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:2];
    assign w_wr      = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.q_limit    <= {NUM_QUEUES{HW_RESET}};
            r_cfg.share_mask <= '1;
            r_cfg.draining   <= 1'b0;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_HW_Q0: r_cfg.q_limit[0]    <= pwdata[HW_W-1:0];
                REG_HW_Q1: r_cfg.q_limit[1]    <= pwdata[HW_W-1:0];
                REG_HW_Q2: r_cfg.q_limit[2]    <= pwdata[HW_W-1:0];
                REG_HW_Q3: r_cfg.q_limit[3]    <= pwdata[HW_W-1:0];
                REG_SHARE: r_cfg.share_mask    <= pwdata[NUM_QUEUES-1:0];
                REG_DRAIN: r_cfg.draining      <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back
    always_comb begin
        prdata = '0;
        case (w_reg_idx)
            REG_HW_Q0: prdata = DATA_W'(r_cfg.q_limit[0]);
            REG_HW_Q1: prdata = DATA_W'(r_cfg.q_limit[1]);
            REG_HW_Q2: prdata = DATA_W'(r_cfg.q_limit[2]);
            REG_HW_Q3: prdata = DATA_W'(r_cfg.q_limit[3]);
            REG_SHARE: prdata = DATA_W'(r_cfg.share_mask);
            REG_DRAIN: prdata = DATA_W'(r_cfg.draining);
            default:   prdata = '0;
        endcase
    end

    lltd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lltd_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg                 (r_cfg),
        .i_cmd                 (w_cmd),
        .o_status              (w_status),
        .i_in_mode             (i_in_mode),
        .i_in_auto_pick        (i_in_auto_pick),
        .i_in_queue_id         (i_in_queue_id),
        .i_in_task_handle      (i_in_task_handle),
        .i_in_task_argument    (i_in_task_argument),
        .o_out_accepted        (o_out_accepted),
        .o_out_chosen_queue    (o_out_chosen_queue),
        .o_out_routed_handle   (o_out_routed_handle),
        .o_out_routed_argument (o_out_routed_argument),
        .o_out_depth_after     (o_out_depth_after)
    );

endmodule
